[design/pscnt_pkg.sv]
package pscnt_pkg;

  localparam int unsigned MaxSources  = 8;
  localparam int unsigned CounterBits = 48;
  localparam int unsigned CountBits   = 32;
  localparam int unsigned OutBits     = 48;
  localparam int unsigned AddrW       = 4;
  localparam int unsigned DataW       = 32;

  localparam logic [3:0]           ActiveReset = 4'd8;
  localparam logic [CountBits-1:0] MinReset    = 32'd2;
  localparam logic [CountBits-1:0] MaxReset    = 32'd1 << 30;

  typedef enum logic [1:0] {
    RegActive = 2'd0,
    RegMin    = 2'd1,
    RegMax    = 2'd2,
    RegNone   = 2'd3
  } reg_e;

  typedef enum logic {
    ReqKey  = 1'b0,
    ReqRead = 1'b1
  } req_e;

  typedef struct packed {
    req_e                 req_type;
    logic [CountBits-1:0] count_0;
    logic [CountBits-1:0] count_1;
    logic [CountBits-1:0] count_2;
    logic [CountBits-1:0] count_3;
    logic [CountBits-1:0] count_4;
    logic [CountBits-1:0] count_5;
    logic [CountBits-1:0] count_6;
    logic [CountBits-1:0] count_7;
    logic [2:0]           first_source;
    logic [2:0]           second_source;
  } in_item_t;

  typedef struct packed {
    logic [OutBits-1:0] pair_count;
    logic [OutBits-1:0] total_count;
  } out_item_t;

  typedef struct packed {
    logic [CountBits-1:0] min_abundance;
    logic [CountBits-1:0] max_abundance;
  } thr_t;

  // diagonal-major slot of pair (lo, hi), lo <= hi < n
  function automatic logic [5:0] pair_slot(logic [2:0] lo, logic [2:0] hi, logic [3:0] n);
    logic [2:0] d;
    logic [2:0] dm;
    logic [5:0] tri_v;
    begin
      d     = hi - lo;
      dm    = (d != 3'd0) ? (d - 3'd1) : 3'd0;
      tri_v = (6'(d) * 6'(dm)) >> 1;
      return 6'(n) * 6'(d) - tri_v + 6'(lo);
    end
  endfunction

endpackage

[design/pairwise_shared_item_counter_core.sv]
// Pairwise shared item counter.
// Input channel (in_valid_i / in_stall_o, in_item_i): a key item (req_type 0)
// carries one abundance count per source; a source is present when its count
// lies in [min_abundance, max_abundance] and its index is below active_sources.
// Every pair i <= j of present sources has its counter incremented, all pairs
// in the same cycle. A read item (req_type 1) names a pair and yields one item
// on the output channel (out_valid_o / out_stall_i, out_item_o) with the pair
// counter and the saturated sum of all counters. Key items yield nothing.
// Throughput: one item per cycle while no read waits on a stalled output; the
// presence compare, the counter cells and the running-total adder are separate
// register stages, and a read result then goes to the output register.
// A stalled result holds in the output register; key items keep flowing, and
// the input stalls once a read waits behind it and one more item has entered.
// Registers at 0x0, 0x4, 0x8 on the APB-style port: the user must write them
// only while idle; the block does not enforce it. Reset clears all counters
// and the total and restores register defaults (8 sources, range 2 to 2^30).
module pairwise_shared_item_counter_core #(
  parameter int unsigned MAX_SOURCES  = pscnt_pkg::MaxSources,
  parameter int unsigned COUNTER_BITS = pscnt_pkg::CounterBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pscnt_pkg::AddrW-1:0]  paddr,
  input  logic [pscnt_pkg::DataW-1:0]  pwdata,
  output logic [pscnt_pkg::DataW-1:0]  prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  pscnt_pkg::in_item_t          in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output pscnt_pkg::out_item_t         out_item_o
);
  import pscnt_pkg::*;

  localparam int unsigned NumPairs = MAX_SOURCES * (MAX_SOURCES + 1) / 2;
  localparam int unsigned SlotW    = (NumPairs > 1) ? $clog2(NumPairs) : 1;
  localparam int unsigned NW       = $clog2(NumPairs + 1);
  localparam int unsigned TW       = COUNTER_BITS + 1;
  localparam logic [COUNTER_BITS-1:0] CMax = {COUNTER_BITS{1'b1}};

  // configuration
  logic [3:0]           active_q;
  logic [CountBits-1:0] min_q;
  logic [CountBits-1:0] max_q;
  logic                 cfg_wr;
  reg_e                 reg_idx;
  thr_t                 thr;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_e'(paddr[AddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ActiveReset;
      min_q    <= MinReset;
      max_q    <= MaxReset;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        RegActive: active_q <= pwdata[3:0];
        RegMin:    min_q    <= pwdata;
        RegMax:    max_q    <= pwdata;
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegActive: prdata = DataW'(active_q);
      RegMin:    prdata = min_q;
      RegMax:    prdata = max_q;
      default:   prdata = '0;
    endcase
  end

  assign thr.min_abundance = min_q;
  assign thr.max_abundance = max_q;

  // presence lanes
  logic [CountBits-1:0]   counts [8];
  logic [MAX_SOURCES-1:0] mask_d;

  assign counts[0] = in_item_i.count_0;
  assign counts[1] = in_item_i.count_1;
  assign counts[2] = in_item_i.count_2;
  assign counts[3] = in_item_i.count_3;
  assign counts[4] = in_item_i.count_4;
  assign counts[5] = in_item_i.count_5;
  assign counts[6] = in_item_i.count_6;
  assign counts[7] = in_item_i.count_7;

  for (genvar l = 0; l < MAX_SOURCES; l++) begin : g_lane
    pscnt_lane u_lane (
      .count_i   (counts[l]),
      .thr_i     (thr),
      .enable_i  (4'(l) < active_q),
      .present_o (mask_d[l])
    );
  end

  // read pair ordering
  logic [2:0] src_lo;
  logic [2:0] src_hi;
  logic [5:0] slot_full;
  logic       rin_d;

  assign src_lo    = (in_item_i.first_source < in_item_i.second_source) ?
                     in_item_i.first_source : in_item_i.second_source;
  assign src_hi    = (in_item_i.first_source < in_item_i.second_source) ?
                     in_item_i.second_source : in_item_i.first_source;
  assign slot_full = pair_slot(src_lo, src_hi, 4'(MAX_SOURCES));
  assign rin_d     = ({1'b0, src_hi} < 4'(MAX_SOURCES));

  // pipeline control
  logic                    v1_q, v2_q, out_v_q;
  req_e                    type1_q, type2_q;
  logic [MAX_SOURCES-1:0]  mask1_q;
  logic [SlotW-1:0]        slot1_q;
  logic                    rin1_q, rin2_q;
  logic [NW-1:0]           n2_q;
  logic [COUNTER_BITS-1:0] pair2_q;
  logic [COUNTER_BITS-1:0] total_q;
  logic                    in_acc, s1_adv, s2_adv;
  logic [COUNTER_BITS-1:0] rd_data;
  logic [NW-1:0]           inc_count;

  assign s2_adv     = v2_q && ((type2_q == ReqKey) || !out_v_q || !out_stall_i);
  assign s1_adv     = v1_q && (!v2_q || s2_adv);
  assign in_stall_o = v1_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (!in_stall_o) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      type1_q <= in_item_i.req_type;
      mask1_q <= mask_d;
      slot1_q <= slot_full[SlotW-1:0];
      rin1_q  <= rin_d;
    end
  end

  pscnt_pair_array #(
    .MAX_SOURCES  (MAX_SOURCES),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_pairs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .upd_en_i    (s1_adv && (type1_q == ReqKey)),
    .mask_i      (mask1_q),
    .rd_slot_i   (slot1_q),
    .rd_data_o   (rd_data),
    .inc_count_o (inc_count)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (s1_adv) begin
      v2_q <= 1'b1;
    end else if (s2_adv) begin
      v2_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      type2_q <= type1_q;
      n2_q    <= inc_count;
      pair2_q <= rd_data;
      rin2_q  <= rin1_q;
    end
  end

  // merge: running total
  logic [TW-1:0] tsum;

  assign tsum = {1'b0, total_q} + TW'(n2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else if (s2_adv && (type2_q == ReqKey)) begin
      total_q <= (tsum > {1'b0, CMax}) ? CMax : tsum[COUNTER_BITS-1:0];
    end
  end

  // output clamp and register
  logic [OutBits-1:0] pair_out, total_out;

  if (COUNTER_BITS > OutBits) begin : g_clamp
    assign pair_out  = (|pair2_q[COUNTER_BITS-1:OutBits]) ? '1 : pair2_q[OutBits-1:0];
    assign total_out = (|total_q[COUNTER_BITS-1:OutBits]) ? '1 : total_q[OutBits-1:0];
  end else begin : g_ext
    assign pair_out  = OutBits'(pair2_q);
    assign total_out = OutBits'(total_q);
  end

  out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (s2_adv && (type2_q == ReqRead)) begin
      out_v_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv && (type2_q == ReqRead)) begin
      out_q.pair_count  <= rin2_q ? pair_out : '0;
      out_q.total_count <= total_out;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

`ifndef NO_ASSERTIONS
  a_stall_needs_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q))
    else $error("input stalled without a blocked item");

  a_total_monotonic : assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (total_q >= $past(total_q)))
    else $error("running total decreased");

  a_pair_le_total : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.pair_count <= out_item_o.total_count))
    else $error("pair count exceeds total");

  a_result_from_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(v2_q && (type2_q == ReqRead)))
    else $error("result not caused by a read item");
`endif

endmodule

[design/pscnt_lane.sv]
module pscnt_lane (
  input  logic [pscnt_pkg::CountBits-1:0] count_i,
  input  pscnt_pkg::thr_t                 thr_i,
  input  logic                            enable_i,
  output logic                            present_o
);
  import pscnt_pkg::*;

  assign present_o = enable_i && (count_i >= thr_i.min_abundance) &&
                     (count_i <= thr_i.max_abundance);

endmodule

[design/pscnt_pair_array.sv]
module pscnt_pair_array #(
  parameter int unsigned MAX_SOURCES  = pscnt_pkg::MaxSources,
  parameter int unsigned COUNTER_BITS = pscnt_pkg::CounterBits,
  localparam int unsigned NumPairs = MAX_SOURCES * (MAX_SOURCES + 1) / 2,
  localparam int unsigned SlotW    = (NumPairs > 1) ? $clog2(NumPairs) : 1,
  localparam int unsigned NW       = $clog2(NumPairs + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    upd_en_i,
  input  logic [MAX_SOURCES-1:0]  mask_i,
  input  logic [SlotW-1:0]        rd_slot_i,
  output logic [COUNTER_BITS-1:0] rd_data_o,
  output logic [NW-1:0]           inc_count_o
);
  import pscnt_pkg::*;

  logic [COUNTER_BITS-1:0] cnt_q [NumPairs];
  logic [NumPairs-1:0]     inc;

  for (genvar i = 0; i < MAX_SOURCES; i++) begin : g_row
    for (genvar j = i; j < MAX_SOURCES; j++) begin : g_col
      localparam int unsigned Slot = int'(pair_slot(3'(i), 3'(j), 4'(MAX_SOURCES)));

      assign inc[Slot] = upd_en_i && mask_i[i] && mask_i[j] && (cnt_q[Slot] != '1);

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          cnt_q[Slot] <= '0;
        end else if (inc[Slot]) begin
          cnt_q[Slot] <= cnt_q[Slot] + COUNTER_BITS'(1);
        end
      end
    end
  end

  assign inc_count_o = NW'($countones(inc));
  assign rd_data_o   = cnt_q[rd_slot_i];

endmodule
